// ===== hdl/ssdbm_pkg.sv =====
// Shared types, constants and the pixel cost function of the SSD block matcher.
`default_nettype none

package ssdbm_pkg;

    localparam int ROW_W  = 10;
    localparam int COL_W  = 12;
    localparam int SLOT_W = 4;
    localparam int CALC_W = 14;
    localparam int DISP_W = 7;
    localparam int DHI_W  = 6;
    localparam int COST_W = 24;
    localparam int PIX_W  = 24;
    localparam int PCOST_W = 18;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DISP_LOW     = 2'd2;
    localparam logic [1:0] REG_DISP_HIGH    = 2'd3;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [DISP_W-1:0] RST_DISP_LOW = 7'h4E;  // -50
    localparam logic [DHI_W-1:0] RST_DISP_HIGH = 6'd50;

    typedef struct packed {
        logic [COL_W-1:0]         width;
        logic [10:0]              height;
        logic signed [DISP_W-1:0] disp_low;
        logic [DHI_W-1:0]         disp_high;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0]  ci;
        logic [COL_W-1:0]  jlo;
        logic [COL_W-1:0]  jhi;
        logic [SLOT_W-1:0] slot;
    } job_t;

    typedef struct packed {
        logic [ROW_W-1:0]         center_row;
        logic [ROW_W-1:0]         center_col;
        logic signed [DISP_W-1:0] disparity;
        logic [COST_W-1:0]        best_cost;
        logic                     last;
    } result_t;

    function automatic logic [PCOST_W-1:0] pix_cost(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [7:0]         ad;
        logic [PCOST_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            ad = (a[8*k +: 8] > b[8*k +: 8]) ? a[8*k +: 8] - b[8*k +: 8]
                                             : b[8*k +: 8] - a[8*k +: 8];
            acc = acc + PCOST_W'(ad) * PCOST_W'(ad);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/stereo_ssd_block_matcher.sv =====
// Top level of the stereo SSD block matcher: register port and module wiring.
`default_nettype none

// Raster stream of aligned left/right RGB pixels in, one word per window centre
// out (row, column, best disparity, SSD cost, tlast on the final word caused by
// a pixel). A single pixel-cost unit evaluates one window tap per cycle while
// the output is not stalled, so a centre takes (disparity_high - disparity_low
// + 1) * (2*HALF_BLOCK+1)^2 taps, or one when the search range is empty; each
// job adds a load step, and a word passes the s1, s2 and output registers after
// the last tap of its centre. Most pixels cause at most one centre; the last pixel
// of a row causes up to disparity_high+1 centres.
// Pixels are taken while the search runs until the two-entry job queue is
// full; the first pixel of a row waits until every search of the previous row
// is done, since it overwrites the oldest line store slot. The line stores
// need no clearing after reset. Register writes restart the frame.
module stereo_ssd_block_matcher #(
    parameter int MAX_WIDTH  = 1024,
    parameter int HALF_BLOCK = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // left_chan0, left_chan1, left_chan2, right_chan0, right_chan1, right_chan2
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // center_row, center_col, disparity, best_cost, zero fill
    output logic      [55:0] m_axis_tdata,
    output logic             m_axis_tlast
);
    import ssdbm_pkg::*;

    localparam int WIN = 2*HALF_BLOCK+1;
    localparam int AW  = $clog2(WIN*MAX_WIDTH);

    logic [10:0]        width_reg, height_reg;
    logic [DISP_W-1:0]  dlow_reg;
    logic [DHI_W-1:0]   dhigh_reg;
    logic               cfg_wr;
    cfg_t               cfg;

    logic               q_push, q_pop, q_full, q_empty, back_idle;
    job_t               push_job, head_job;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr_l, rd_addr_r;
    logic [PIX_W-1:0]   wr_left, wr_right, rd_left, rd_right;
    result_t            res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            dlow_reg   <= RST_DISP_LOW;
            dhigh_reg  <= RST_DISP_HIGH;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[10:0];
                REG_DISP_LOW:     dlow_reg   <= pwdata[DISP_W-1:0];
                REG_DISP_HIGH:    dhigh_reg  <= pwdata[DHI_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            REG_DISP_LOW:     prdata = 32'(dlow_reg);
            REG_DISP_HIGH:    prdata = 32'(dhigh_reg);
            default:          prdata = '0;
        endcase
    end

    // sizes saturated to what the line stores and counters hold
    always_comb
    begin
        if (width_reg == '0)
            cfg.width = COL_W'(1);
        else if (width_reg > MAX_WIDTH)
            cfg.width = COL_W'(MAX_WIDTH);
        else
            cfg.width = COL_W'(width_reg);
        if (height_reg == '0)
            cfg.height = 11'd1;
        else if (height_reg > 11'd1024)
            cfg.height = 11'd1024;
        else
            cfg.height = height_reg;
        cfg.disp_low  = dlow_reg;
        cfg.disp_high = dhigh_reg;
    end

    ssdbm_front #(.MAX_WIDTH(MAX_WIDTH), .HALF_BLOCK(HALF_BLOCK)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_wr    (cfg_wr),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .back_idle (back_idle),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .push      (q_push),
        .job       (push_job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_left   (wr_left),
        .wr_right  (wr_right)
    );

    ssdbm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    ssdbm_lines #(.DEPTH(WIN*MAX_WIDTH)) u_lines (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_left   (wr_left),
        .wr_right  (wr_right),
        .rd_en     (rd_en),
        .rd_addr_l (rd_addr_l),
        .rd_addr_r (rd_addr_r),
        .rd_left   (rd_left),
        .rd_right  (rd_right)
    );

    ssdbm_back #(.MAX_WIDTH(MAX_WIDTH), .HALF_BLOCK(HALF_BLOCK)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (!q_empty),
        .job       (head_job),
        .job_pop   (q_pop),
        .idle      (back_idle),
        .rd_en     (rd_en),
        .rd_addr_l (rd_addr_l),
        .rd_addr_r (rd_addr_r),
        .rd_left   (rd_left),
        .rd_right  (rd_right),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_result  (res)
    );

    assign m_axis_tdata = {5'b0, res.best_cost, res.disparity, res.center_col, res.center_row};
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== hdl/ssdbm_lines.sv =====
// Left and right line stores: one write port, one registered read port each.
`default_nettype none

module ssdbm_lines #(
    parameter int DEPTH = 7168
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [ssdbm_pkg::PIX_W-1:0] wr_left,
    input  wire logic [ssdbm_pkg::PIX_W-1:0] wr_right,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_l,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_r,
    output logic      [ssdbm_pkg::PIX_W-1:0] rd_left,
    output logic      [ssdbm_pkg::PIX_W-1:0] rd_right
);
    import ssdbm_pkg::*;

    logic [PIX_W-1:0] left_mem  [DEPTH];
    logic [PIX_W-1:0] right_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= wr_left;
            right_mem[wr_addr] <= wr_right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_left  <= left_mem[rd_addr_l];
            rd_right <= right_mem[rd_addr_r];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssdbm_front.sv =====
// Front end: raster counters, line store writes and match job generation.
`default_nettype none

module ssdbm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int HALF_BLOCK = 3
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ssdbm_pkg::cfg_t         cfg,
    input  wire logic                    cfg_wr,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [47:0]             s_data,
    input  wire logic                    back_idle,
    input  wire logic                    q_full,
    input  wire logic                    q_empty,
    output logic                         push,
    output ssdbm_pkg::job_t              job,
    output logic                         wr_en,
    output logic [$clog2((2*HALF_BLOCK+1)*MAX_WIDTH)-1:0] wr_addr,
    output logic [ssdbm_pkg::PIX_W-1:0]  wr_left,
    output logic [ssdbm_pkg::PIX_W-1:0]  wr_right
);
    import ssdbm_pkg::*;

    localparam int WIN = 2*HALF_BLOCK+1;
    localparam int AW  = $clog2(WIN*MAX_WIDTH);

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  col_reg, col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              wrap, accept;
    logic [ROW_W-1:0]  r, c;
    logic [SLOT_W-1:0] slot, slot_inc;
    logic [ROW_W:0]    c1, r1;
    logic signed [CALC_W-1:0] cs, ws, hb, dh, lim, jlo, jhi;

    // counters past a shrunken frame restart at the origin
    assign wrap = ({1'b0, row_reg} >= cfg.height) || ({2'b0, col_reg} >= cfg.width);
    assign r    = wrap ? '0 : row_reg;
    assign c    = wrap ? '0 : col_reg;
    assign slot = wrap ? '0 : slot_reg;
    assign slot_inc = (slot == SLOT_W'(WIN-1)) ? '0 : slot + SLOT_W'(1);

    // a new row overwrites the oldest slot, so wait until all searches are done
    assign s_ready = !q_full && ((c != '0) || (q_empty && back_idle));
    assign accept  = s_valid && s_ready;

    always_comb
    begin
        cs  = CALC_W'(c);
        ws  = CALC_W'(cfg.width);
        hb  = CALC_W'(HALF_BLOCK);
        dh  = CALC_W'(cfg.disp_high);
        lim = ws - CALC_W'(1) - hb;
        if (cs < ws - CALC_W'(1))
        begin
            jlo = cs - hb - dh;
            jhi = jlo;
        end
        else
        begin
            jlo = lim - dh;
            jhi = lim;
        end
        if (jlo < hb)
            jlo = hb;
        if (jhi > lim)
            jhi = lim;
    end

    assign push     = accept && (r >= ROW_W'(2*HALF_BLOCK)) && (jlo <= jhi);
    assign job.ci   = r - ROW_W'(HALF_BLOCK);
    assign job.jlo  = jlo[COL_W-1:0];
    assign job.jhi  = jhi[COL_W-1:0];
    assign job.slot = slot_inc;

    assign wr_en    = accept;
    assign wr_addr  = AW'(slot) * AW'(MAX_WIDTH) + AW'(c);
    assign wr_left  = s_data[23:0];
    assign wr_right = s_data[47:24];

    assign c1 = {1'b0, c} + (ROW_W+1)'(1);
    assign r1 = {1'b0, r} + (ROW_W+1)'(1);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (cfg_wr)
        begin
            row_next  = '0;
            col_next  = '0;
            slot_next = '0;
        end
        else if (accept)
        begin
            if ({1'b0, c1} >= cfg.width)
            begin
                col_next = '0;
                if (r1 >= cfg.height)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = r1[ROW_W-1:0];
                    slot_next = slot_inc;
                end
            end
            else
            begin
                col_next  = c1[ROW_W-1:0];
                row_next  = r;
                slot_next = slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssdbm_queue.sv =====
// Two-entry job queue between front end and matcher.
`default_nettype none

module ssdbm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ssdbm_pkg::job_t push_job,
    input  wire logic            pop,
    output ssdbm_pkg::job_t      head,
    output logic                 full,
    output logic                 empty
);
    import ssdbm_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssdbm_back.sv =====
// Matcher: walks centres, disparities and window taps through one cost unit.
`default_nettype none

module ssdbm_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int HALF_BLOCK = 3
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ssdbm_pkg::cfg_t         cfg,
    input  wire logic                    job_valid,
    input  wire ssdbm_pkg::job_t         job,
    output logic                         job_pop,
    output logic                         idle,
    output logic                         rd_en,
    output logic [$clog2((2*HALF_BLOCK+1)*MAX_WIDTH)-1:0] rd_addr_l,
    output logic [$clog2((2*HALF_BLOCK+1)*MAX_WIDTH)-1:0] rd_addr_r,
    input  wire logic [ssdbm_pkg::PIX_W-1:0] rd_left,
    input  wire logic [ssdbm_pkg::PIX_W-1:0] rd_right,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output ssdbm_pkg::result_t           m_result
);
    import ssdbm_pkg::*;

    localparam int WIN   = 2*HALF_BLOCK+1;
    localparam int AW    = $clog2(WIN*MAX_WIDTH);
    localparam int SUM_W = $clog2(WIN*WIN*195075+1);
    localparam int EXT_W = (SUM_W > COST_W) ? SUM_W : COST_W;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     lastd;
        logic                     lastc;
        logic                     empty;
        logic                     last;
        logic signed [DISP_W-1:0] d;
        logic [ROW_W-1:0]         ci;
        logic [COL_W-1:0]         j;
    } tok_t;

    logic                     busy_reg;
    logic [ROW_W-1:0]         ci_reg;
    logic [COL_W-1:0]         j_reg, jhi_reg;
    logic [SLOT_W-1:0]        slot0_reg, slot_reg, dy_reg, dx_reg;
    logic signed [DISP_W-1:0] d_reg;

    tok_t                 tok, s1_reg, s2_reg;
    logic [PCOST_W-1:0]   cost_reg;
    logic [SUM_W-1:0]     sum_reg, best_reg, sum_next;
    logic signed [DISP_W-1:0] bestd_reg;
    logic                 have_reg, better, res_load, adv, out_free, empty;
    logic                 out_valid_reg;
    result_t              out_reg, res;
    logic signed [CALC_W-1:0] lc, rc, ws;
    logic [SUM_W-1:0]     fin_cost;
    logic [EXT_W-1:0]     fin_ext;

    assign empty = $signed({cfg.disp_low[DISP_W-1], cfg.disp_low})
                 > $signed({2'b00, cfg.disp_high});

    always_comb
    begin
        tok.valid = busy_reg;
        tok.first = (dx_reg == '0) && (dy_reg == '0);
        tok.lastd = empty || ((dx_reg == SLOT_W'(WIN-1)) && (dy_reg == SLOT_W'(WIN-1)));
        tok.lastc = empty || ({d_reg[DISP_W-1], d_reg} == {2'b00, cfg.disp_high});
        tok.empty = empty;
        tok.last  = (j_reg == jhi_reg);
        tok.d     = d_reg;
        tok.ci    = ci_reg;
        tok.j     = j_reg;
    end

    // right column is clamped to the image
    always_comb
    begin
        ws = CALC_W'(cfg.width);
        lc = CALC_W'(j_reg) + CALC_W'(dx_reg) - CALC_W'(HALF_BLOCK);
        rc = lc + CALC_W'(d_reg);
        if (rc < CALC_W'(0))
            rc = '0;
        if (rc > ws - CALC_W'(1))
            rc = ws - CALC_W'(1);
    end

    assign rd_addr_l = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(lc[COL_W-1:0]);
    assign rd_addr_r = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(rc[COL_W-1:0]);

    assign out_free = !out_valid_reg || m_ready;
    assign adv      = !(s2_reg.valid && s2_reg.lastd && s2_reg.lastc && !out_free);
    assign rd_en    = adv;
    assign job_pop  = !busy_reg && job_valid && adv;
    assign idle     = !busy_reg;

    // accumulate and keep first strict minimum
    always_comb
    begin
        sum_next = (s2_reg.first ? '0 : sum_reg) + SUM_W'(cost_reg);
        better   = !have_reg || (sum_next < best_reg);
        res_load = adv && s2_reg.valid && s2_reg.lastd && s2_reg.lastc;
        fin_cost = better ? sum_next : best_reg;
        fin_ext  = EXT_W'(fin_cost);
        res.center_row = s2_reg.ci;
        res.center_col = s2_reg.j[ROW_W-1:0];
        res.last       = s2_reg.last;
        if (s2_reg.empty)
        begin
            res.disparity = '0;
            res.best_cost = COST_MAX;
        end
        else
        begin
            res.disparity = better ? s2_reg.d : bestd_reg;
            res.best_cost = (fin_ext > EXT_W'(COST_MAX)) ? COST_MAX : fin_ext[COST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_reg <= tok;
                s2_reg <= s1_reg;
                if (job_pop)
                    busy_reg <= 1'b1;
                else if (busy_reg && tok.lastd && tok.lastc && tok.last)
                    busy_reg <= 1'b0;
                if (s2_reg.valid && !s2_reg.empty && s2_reg.lastd)
                    have_reg <= !s2_reg.lastc;
            end
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (job_pop)
            begin
                ci_reg    <= job.ci;
                j_reg     <= job.jlo;
                jhi_reg   <= job.jhi;
                slot0_reg <= job.slot;
                slot_reg  <= job.slot;
                d_reg     <= cfg.disp_low;
                dy_reg    <= '0;
                dx_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (empty || dx_reg == SLOT_W'(WIN-1))
                begin
                    dx_reg <= '0;
                    if (empty || dy_reg == SLOT_W'(WIN-1))
                    begin
                        dy_reg   <= '0;
                        slot_reg <= slot0_reg;
                        if (tok.lastc)
                        begin
                            d_reg <= cfg.disp_low;
                            j_reg <= j_reg + COL_W'(1);
                        end
                        else
                            d_reg <= d_reg + DISP_W'(1);
                    end
                    else
                    begin
                        dy_reg   <= dy_reg + SLOT_W'(1);
                        slot_reg <= (slot_reg == SLOT_W'(WIN-1)) ? '0 : slot_reg + SLOT_W'(1);
                    end
                end
                else
                    dx_reg <= dx_reg + SLOT_W'(1);
            end
            cost_reg <= pix_cost(rd_left, rd_right);
            if (s2_reg.valid && !s2_reg.empty)
            begin
                sum_reg <= sum_next;
                if (s2_reg.lastd && better)
                begin
                    best_reg  <= sum_next;
                    bestd_reg <= s2_reg.d;
                end
            end
        end
        if (res_load)
            out_reg <= res;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (job_valid && !busy_reg))
        else $error("job taken while a search is running");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result overwrites a word not yet taken");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> m_valid)
        else $error("finished centre did not reach the output");

endmodule

`default_nettype wire

// ===== dv/tb_stereo_ssd_block_matcher.sv =====
// Self-checking testbench for the stereo SSD block matcher: stream stimulus, APB setup, scoreboard.
`default_nettype none

module tb_stereo_ssd_block_matcher;
    import ssdbm_pkg::*;

    localparam int MAXW     = 1024;
    localparam int HB       = 3;
    localparam int WROWS    = 2 * HB + 1;
    localparam int IDLE_GAP = 7000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    stereo_ssd_block_matcher #(.MAX_WIDTH(MAXW), .HALF_BLOCK(HB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // mirror of the block state
    bit [23:0]       left_px  [WROWS*MAXW];
    bit [23:0]       right_px [WROWS*MAXW];
    int              row_cnt;
    int              col_cnt;
    bit [10:0]       cfg_width;
    bit [10:0]       cfg_height;
    bit signed [6:0] cfg_dlo;
    bit [5:0]        cfg_dhi;

    bit [47:0] pixel_q[$];
    result_t   match_q[$];
    int        err_cnt;
    int        snd_idle_pct;
    int        rcv_stall_pct;
    logic      hold_go;
    logic      hold_used;
    int        hold_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    function automatic void match_center(input int ci, input int cj, input int w,
                                         output bit [6:0] bd, output bit [23:0] bc);
        longint unsigned best;
        longint unsigned sum;
        bit              have;
        int              dsp;
        int              slot;
        int              rc;
        int              df;
        bit [23:0]       lp;
        bit [23:0]       rp;
        have = 0;
        best = 0;
        bd = '0;
        for (int d = int'(cfg_dlo); d <= int'(cfg_dhi); d++)
        begin
            sum = 0;
            for (int dy = -HB; dy <= HB; dy++)
            begin
                slot = (ci + dy) % WROWS;
                for (int dx = -HB; dx <= HB; dx++)
                begin
                    rc = cj + dx + d;
                    if (rc < 0) rc = 0;
                    if (rc > w - 1) rc = w - 1;
                    lp = left_px[slot*MAXW + cj + dx];
                    rp = right_px[slot*MAXW + rc];
                    for (int k = 0; k < 3; k++)
                    begin
                        df = int'(lp[8*k +: 8]) - int'(rp[8*k +: 8]);
                        sum += longint'(df * df);
                    end
                end
            end
            if (!have || sum < best)
            begin
                have = 1;
                best = sum;
                dsp = d;
                bd = dsp[6:0];
            end
        end
        if (!have)
        begin
            bd = '0;
            bc = COST_MAX;
        end
        else
            bc = (best > 64'hFFFFFF) ? COST_MAX : best[23:0];
    endfunction

    function automatic void predict_pixel(input bit [47:0] px);
        int        w;
        int        h;
        int        r;
        int        c;
        int        jlo;
        int        jhi;
        result_t   res;
        bit [6:0]  bd;
        bit [23:0] bc;
        w = (cfg_width < 1) ? 1 : ((cfg_width > MAXW) ? MAXW : int'(cfg_width));
        h = (cfg_height < 1) ? 1 : ((cfg_height > 1024) ? 1024 : int'(cfg_height));
        r = row_cnt;
        c = col_cnt;
        if (r >= h || c >= w)
        begin
            r = 0;
            c = 0;
        end
        left_px[(r % WROWS)*MAXW + c]  = px[23:0];
        right_px[(r % WROWS)*MAXW + c] = px[47:24];
        if (r >= 2 * HB)
        begin
            if (c < w - 1)
            begin
                jlo = c - HB - int'(cfg_dhi);
                jhi = jlo;
            end
            else
            begin
                jlo = w - 1 - HB - int'(cfg_dhi);
                jhi = w - 1 - HB;
            end
            if (jlo < HB) jlo = HB;
            if (jhi > w - 1 - HB) jhi = w - 1 - HB;
            for (int j = jlo; j <= jhi; j++)
            begin
                match_center(r - HB, j, w, bd, bc);
                res.center_row = 10'(r - HB);
                res.center_col = 10'(j);
                res.disparity  = bd;
                res.best_cost  = bc;
                res.last       = (j == jhi);
                match_q.push_back(res);
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_cnt = r & 10'h3FF;
        col_cnt = c & 10'h3FF;
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_q.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_left <= 4000;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (match_q.size() == 0)
                    report($sformatf("unexpected word %h last %b", m_axis_tdata, m_axis_tlast));
                else
                begin
                    want = match_q.pop_front();
                    if (m_axis_tdata[9:0] !== want.center_row)
                        report($sformatf("center_row %0d want %0d",
                                         m_axis_tdata[9:0], want.center_row));
                    if (m_axis_tdata[19:10] !== want.center_col)
                        report($sformatf("center_col %0d want %0d",
                                         m_axis_tdata[19:10], want.center_col));
                    if (m_axis_tdata[26:20] !== want.disparity)
                        report($sformatf("disparity %h want %h (row %0d col %0d)",
                                         m_axis_tdata[26:20], want.disparity,
                                         want.center_row, want.center_col));
                    if (m_axis_tdata[50:27] !== want.best_cost)
                        report($sformatf("best_cost %0d want %0d",
                                         m_axis_tdata[50:27], want.best_cost));
                    if (m_axis_tlast !== want.last)
                        report($sformatf("tlast %b want %b", m_axis_tlast, want.last));
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = val[10:0];
            REG_IMAGE_HEIGHT: cfg_height = val[10:0];
            REG_DISP_LOW:     cfg_dlo    = val[6:0];
            default:          cfg_dhi    = val[5:0];
        endcase
        row_cnt = 0;
        col_cnt = 0;
    endtask

    task automatic setup(input int w, input int h, input int lo, input int hi);
        reg_write(REG_IMAGE_WIDTH, 32'(w));
        reg_write(REG_IMAGE_HEIGHT, 32'(h));
        reg_write(REG_DISP_LOW, 32'(lo) & 32'h7F);
        reg_write(REG_DISP_HIGH, 32'(hi));
    endtask

    function automatic bit [47:0] rand_pixel();
        bit [47:0] px;
        px = {$urandom, $urandom};
        case ($urandom_range(9))
            0: px = '0;
            1: px = '1;
            2: px[23:0] = px[47:24];
            default: ;
        endcase
        return px;
    endfunction

    task automatic run_frame(input int n);
        for (int i = 0; i < n; i++)
            pixel_q.push_back(rand_pixel());
        wait (pixel_q.size() == 0 && !s_axis_tvalid && match_q.size() == 0);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_go       = 1'b0;
        err_cnt       = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        row_cnt       = 0;
        col_cnt       = 0;
        cfg_width     = RST_IMAGE_WIDTH;
        cfg_height    = RST_IMAGE_HEIGHT;
        cfg_dlo       = RST_DISP_LOW;
        cfg_dhi       = RST_DISP_HIGH;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: all-zero, all-one and left/right opposite pixels, no centre yet
        pixel_q.push_back('0);
        pixel_q.push_back('1);
        pixel_q.push_back(48'h0000_00FF_FFFF);
        pixel_q.push_back(48'hFFFF_FF00_0000);
        run_frame(0);

        // a wide search on a small image
        setup(8, 7, -63, 63);
        run_frame(56);

        snd_idle_pct = 77;
        setup(9, 7, -2, 2);
        run_frame(63);

        // receiver stalls, with one long hold-off so the job queue backs up
        snd_idle_pct  = 0;
        rcv_stall_pct = 77;
        setup(12, 9, 0, 0);
        hold_go <= 1'b1;
        run_frame(108);

        // empty search range
        snd_idle_pct  = 20;
        rcv_stall_pct = 20;
        setup(9, 7, 5, 0);
        run_frame(63);

        // saturated sizes, no interior centre reached
        setup(0, 0, -1, 1);
        run_frame(4);
        setup(2047, 2047, -1, 1);
        run_frame(3);
        setup(1024, 1024, -1, 3);
        run_frame(3);

        if (err_cnt == 0)
            $display("[stereo_ssd_block_matcher] OK");
        else
            $display("[stereo_ssd_block_matcher] ERROR");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("[stereo_ssd_block_matcher] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
